>>> sv/schal_pkg.sv
// Package: shared types and constants of the size-class heap allocator.
`default_nettype none
package schal_pkg;
   localparam int unsigned BLOCK_SLOTS_DEF = 8;
   localparam int unsigned REGIONS_PER_BLOCK_DEF = 16;
   localparam int unsigned BLOCK_SPAN_LOG2_DEF = 24;
   localparam int unsigned ADDR_W = 27;
   localparam int unsigned SIZE_W = 25;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SMALL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIUM = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LARGE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MINREG = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RHDR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BHDR   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FIT    = 3'd6;

   localparam logic       CMD_ALLOC   = 1'b0;
   localparam logic       CMD_RELEASE = 1'b1;
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_ZERO     = 2'd1;
   localparam logic [1:0] ST_OOM      = 2'd2;
   localparam logic [1:0] ST_IGNORED  = 2'd3;

   typedef struct packed {
      logic              cmd;
      logic [SIZE_W-1:0] request_bytes;
      logic [ADDR_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] address;
      logic [31:0]       alloc_count;
      logic [31:0]       release_count;
      logic [31:0]       requested_total;
      logic [3:0]        blocks_open;
   } rsp_type;
endpackage
`default_nettype wire

>>> sv/size_class_heap_allocator.sv
// Top level: size-class heap allocator with a region table walked by a sequencer.
//
// Usage: pulse start with req_item while busy is low. The item is one of
// allocate (cmd 0, request_bytes) or release (cmd 1, handle). Exactly one
// result appears later on rsp_item for a single cycle, marked by rsp_valid;
// the receiver cannot stall it, so it must take it in that cycle.
// Configuration: csr_valid/csr_ready with csr_index and csr_data; write
// only while busy is low. Seven registers, index as listed in the package.
// Table: the region table (one entry per slot and region, 128 in all) sits
// in a RAM with one registered read port, so each table access is a read
// request followed by a check of the registered data. An allocate walks
// the regions of open blocks in class and age order and stops at the first
// fitting region, or in best-fit mode at the end of the first block that
// holds one. A split or a merge moves the table tail one entry at a time,
// with a read and a write per entry. A release scans slots in order until
// the handle is found.
// Reset: synchronous, clears all block bookkeeping and statistics and loads
// the register reset values; the table memory needs no clearing since only
// live entries are ever read.
`default_nettype none
module size_class_heap_allocator
   import schal_pkg::*;
#(
   parameter int unsigned BLOCK_SLOTS = BLOCK_SLOTS_DEF,
   parameter int unsigned REGIONS_PER_BLOCK = REGIONS_PER_BLOCK_DEF,
   parameter int unsigned BLOCK_SPAN_LOG2 = BLOCK_SPAN_LOG2_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire req_type              req_item,
   output logic                      rsp_valid,
   output rsp_type                   rsp_item,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data
);
   localparam int unsigned SW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
   localparam int unsigned RW = $clog2(REGIONS_PER_BLOCK);
   localparam int unsigned CW = $clog2(REGIONS_PER_BLOCK + 1);
   localparam int unsigned AW = SW + RW;
   localparam int unsigned DEPTH = BLOCK_SLOTS * REGIONS_PER_BLOCK;
   localparam int unsigned OW = 32;
   localparam int unsigned EW = 2 * OW + 1;
   localparam int unsigned NW = $clog2(BLOCK_SLOTS + 1);

   typedef struct packed {
      logic [OW-1:0] offset;
      logic [OW-1:0] size;
      logic          is_free;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_PREP, S_SRCH_SLOT, S_SRCH_RD, S_SRCH_CHK, S_OPEN,
      S_SPLIT_RD, S_SPLIT_CHK, S_SHR_RD, S_SHR_WR, S_SPLIT_WR,
      S_REL_SLOT, S_REL_RD, S_REL_CHK, S_PREV_RD, S_PREV_CHK,
      S_NEXT_RD, S_NEXT_CHK, S_SHL_RD, S_SHL_WR, S_REL_FIN, S_RESP
   } state_type;

   // configuration
   logic [SIZE_W-1:0] cfg_blk_ff [3];
   logic [12:0] cfg_min_ff;
   logic [7:0]  cfg_rhdr_ff, cfg_bhdr_ff;
   logic        cfg_fit_ff;

   // block bookkeeping
   logic          open_ff  [BLOCK_SLOTS];
   logic [1:0]    class_ff [BLOCK_SLOTS];
   logic [SW-1:0] rank_ff  [BLOCK_SLOTS];
   logic [CW-1:0] count_ff [BLOCK_SLOTS];
   logic [NW-1:0] nopen_ff;
   logic [31:0]   atally_ff, rtally_ff, rsum_ff;

   state_type state_ff;
   req_type   req_ff;
   logic [SIZE_W-1:0] s_ff;          // rounded size
   logic [1:0]    cls_ff;
   logic [SW-1:0] rk_ff, slot_ff;
   logic [CW-1:0] idx_ff, k_ff;
   logic          found_ff;
   logic [CW-1:0] best_ff;
   logic [OW-1:0] bsize_ff;
   entry_type     cur_ff, nb_ff;
   logic [1:0]    status_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic          rsp_valid_ff;

   // memory
   logic          mwe;
   logic [AW-1:0] mwa, mra;
   entry_type     mwd, mrd;

   schal_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(mwe), .waddr(mwa), .wdata(mwd),
      .raddr(mra), .rdata(mrd)
   );

   function automatic logic [AW-1:0] ea(input logic [SW-1:0] b, input logic [CW-1:0] i);
      ea = AW'((int'(b) * REGIONS_PER_BLOCK) + int'(i));
   endfunction

   logic [8:0] hdr_sum;
   assign hdr_sum = {1'b0, cfg_rhdr_ff} + {1'b0, cfg_bhdr_ff};

   function automatic logic [SIZE_W-1:0] cap(input logic [SIZE_W-1:0] bytes,
                                            input logic [8:0] h);
      cap = (bytes > SIZE_W'(h)) ? bytes - SIZE_W'(h) : '0;
   endfunction

   logic [SIZE_W-1:0] cap_sel;
   assign cap_sel = cap(cfg_blk_ff[cls_ff], hdr_sum);

   // address of current entry
   logic [ADDR_W-1:0] cur_addr;
   always_comb begin
      logic [63:0] a;
      a = (64'(slot_ff) << BLOCK_SPAN_LOG2) + 64'(cfg_bhdr_ff) + 64'(mrd.offset)
          + 64'(cfg_rhdr_ff);
      cur_addr = a[ADDR_W-1:0];
   end

   // slot lookup for search: open slot of class cls_ff and rank rk_ff
   logic          hit;
   logic [SW-1:0] hit_slot;
   always_comb begin
      hit = 1'b0;
      hit_slot = '0;
      for (int b = BLOCK_SLOTS - 1; b >= 0; b--) begin
         if (open_ff[b] && class_ff[b] == cls_ff && rank_ff[b] == rk_ff) begin
            hit = 1'b1;
            hit_slot = SW'(b);
         end
      end
   end

   logic          free_any;
   logic [SW-1:0] free_slot;
   always_comb begin
      free_any = 1'b0;
      free_slot = '0;
      for (int b = BLOCK_SLOTS - 1; b >= 0; b--) begin
         if (!open_ff[b]) begin
            free_any = 1'b1;
            free_slot = SW'(b);
         end
      end
   end

   function automatic logic [31:0] sat(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] r;
      r = {1'b0, a} + {1'b0, b};
      sat = r[32] ? 32'hFFFF_FFFF : r[31:0];
   endfunction

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = '{status: status_ff, address: addr_ff, alloc_count: atally_ff,
                       release_count: rtally_ff, requested_total: rsum_ff,
                       blocks_open: 4'(nopen_ff)};

   logic [CW-1:0] cnt_cur;
   assign cnt_cur = count_ff[slot_ff];
   logic [OW+9:0] need;
   assign need = (OW+10)'(s_ff) + (OW+10)'(cfg_rhdr_ff) + (OW+10)'(cfg_min_ff);

   // memory port control
   always_comb begin
      mwe = 1'b0;
      mwa = ea(slot_ff, idx_ff);
      mwd = cur_ff;
      mra = ea(slot_ff, idx_ff);
      case (state_ff)
         S_SHR_RD: mra = ea(slot_ff, k_ff - CW'(1));
         S_SHR_WR: begin
            mwe = 1'b1;
            mwa = ea(slot_ff, k_ff);
            mwd = mrd;
         end
         S_SPLIT_WR: begin
            mwe = 1'b1;
            mwa = ea(slot_ff, idx_ff);
            mwd = cur_ff;
         end
         S_OPEN: begin
            // only a closed slot may take the fresh region
            mwe = free_any;
            mwa = ea(free_slot, '0);
            mwd = '{offset: '0, size: OW'(cap_sel), is_free: 1'b1};
         end
         S_PREV_RD: mra = ea(slot_ff, idx_ff - CW'(1));
         S_NEXT_RD: mra = ea(slot_ff, idx_ff + CW'(1));
         S_SHL_RD: mra = ea(slot_ff, k_ff + CW'(1));
         S_SHL_WR: begin
            mwe = 1'b1;
            mwa = ea(slot_ff, k_ff);
            mwd = mrd;
         end
         S_REL_FIN: begin
            mwe = 1'b1;
            mwa = ea(slot_ff, idx_ff);
            mwd = cur_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         cfg_blk_ff[0] <= 25'd16384;
         cfg_blk_ff[1] <= 25'd1048576;
         cfg_blk_ff[2] <= 25'd16777216;
         cfg_min_ff <= 13'd256;
         cfg_rhdr_ff <= 8'd32;
         cfg_bhdr_ff <= 8'd16;
         cfg_fit_ff <= 1'b0;
         for (int b = 0; b < BLOCK_SLOTS; b++) begin
            open_ff[b] <= 1'b0;
            class_ff[b] <= '0;
            rank_ff[b] <= '0;
            count_ff[b] <= '0;
         end
         nopen_ff <= '0;
         atally_ff <= '0;
         rtally_ff <= '0;
         rsum_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (csr_valid) begin
                  case (csr_index)
                     CSR_SMALL:  cfg_blk_ff[0] <= csr_data[SIZE_W-1:0];
                     CSR_MEDIUM: cfg_blk_ff[1] <= csr_data[SIZE_W-1:0];
                     CSR_LARGE:  cfg_blk_ff[2] <= csr_data[SIZE_W-1:0];
                     CSR_MINREG: cfg_min_ff <= csr_data[12:0];
                     CSR_RHDR:   cfg_rhdr_ff <= csr_data[7:0];
                     CSR_BHDR:   cfg_bhdr_ff <= csr_data[7:0];
                     CSR_FIT:    cfg_fit_ff <= csr_data[0];
                     default: ;
                  endcase
               end
               if (start) begin
                  req_ff <= req_item;
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               status_ff <= ST_DONE;
               addr_ff <= '0;
               cls_ff <= '0;
               rk_ff <= '0;
               slot_ff <= '0;
               if (req_ff.cmd == CMD_RELEASE) begin
                  if (req_ff.handle == '0) begin
                     status_ff <= ST_IGNORED;
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_REL_SLOT;
                  end
               end else if (req_ff.request_bytes == '0) begin
                  status_ff <= ST_ZERO;
                  state_ff <= S_RESP;
               end else begin
                  logic [SIZE_W:0] r;
                  r = ({1'b0, req_ff.request_bytes} + (SIZE_W+1)'(3)) & ~(SIZE_W+1)'(3);
                  if (r < (SIZE_W+1)'(cfg_min_ff)) r = (SIZE_W+1)'(cfg_min_ff);
                  s_ff <= r[SIZE_W-1:0];
                  // search skipped when above large capacity
                  if (r > (SIZE_W+1)'(cap(cfg_blk_ff[2], hdr_sum))) begin
                     cls_ff <= 2'd3;
                  end
                  // beyond every class capacity: nothing can hold it
                  if (r[SIZE_W]) begin
                     status_ff <= ST_OOM;
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_SRCH_SLOT;
                  end
               end
            end
            S_SRCH_SLOT: begin
               if (cls_ff == 2'd3) begin
                  cls_ff <= '0;
                  state_ff <= S_OPEN;
               end else if (hit) begin
                  slot_ff <= hit_slot;
                  idx_ff <= '0;
                  found_ff <= 1'b0;
                  state_ff <= S_SRCH_RD;
               end else if (rk_ff == SW'(BLOCK_SLOTS - 1)) begin
                  rk_ff <= '0;
                  cls_ff <= cls_ff + 2'd1;
                  if (cls_ff == 2'd2) cls_ff <= '0;
                  if (cls_ff == 2'd2) state_ff <= S_OPEN;
               end else begin
                  rk_ff <= rk_ff + SW'(1);
               end
            end
            S_SRCH_RD: state_ff <= S_SRCH_CHK;
            S_SRCH_CHK: begin
               logic fits, f;
               fits = mrd.is_free && (mrd.size >= OW'(s_ff));
               f = found_ff;
               if (fits && (!found_ff || mrd.size < bsize_ff)) begin
                  f = 1'b1;
                  best_ff <= idx_ff;
                  bsize_ff <= mrd.size;
               end
               found_ff <= f;
               if (fits && !cfg_fit_ff) begin
                  idx_ff <= idx_ff;
                  state_ff <= S_SPLIT_RD;
               end else if (idx_ff + CW'(1) < cnt_cur) begin
                  idx_ff <= idx_ff + CW'(1);
                  state_ff <= S_SRCH_RD;
               end else if (f) begin
                  idx_ff <= fits && (!found_ff || mrd.size < bsize_ff) ? idx_ff : best_ff;
                  state_ff <= S_SPLIT_RD;
               end else if (rk_ff == SW'(BLOCK_SLOTS - 1)) begin
                  rk_ff <= '0;
                  if (cls_ff == 2'd2) begin
                     cls_ff <= '0;
                     state_ff <= S_OPEN;
                  end else begin
                     cls_ff <= cls_ff + 2'd1;
                     state_ff <= S_SRCH_SLOT;
                  end
               end else begin
                  rk_ff <= rk_ff + SW'(1);
                  state_ff <= S_SRCH_SLOT;
               end
            end
            S_OPEN: begin
               // walk classes until capacity holds the size; the fresh entry is rewritten at each class step
               if (32'(nopen_ff) >= BLOCK_SLOTS || !free_any) begin
                  status_ff <= ST_OOM;
                  state_ff <= S_RESP;
               end else if (s_ff <= cap_sel && cap_sel != '0) begin
                  for (int b = 0; b < BLOCK_SLOTS; b++)
                     if (open_ff[b]) rank_ff[b] <= rank_ff[b] + SW'(1);
                  open_ff[free_slot] <= 1'b1;
                  class_ff[free_slot] <= cls_ff;
                  rank_ff[free_slot] <= '0;
                  count_ff[free_slot] <= CW'(1);
                  nopen_ff <= nopen_ff + NW'(1);
                  slot_ff <= free_slot;
                  idx_ff <= '0;
                  state_ff <= S_SPLIT_RD;
               end else if (cls_ff == 2'd2) begin
                  status_ff <= ST_OOM;
                  state_ff <= S_RESP;
               end else begin
                  cls_ff <= cls_ff + 2'd1;
               end
            end
            S_SPLIT_RD: state_ff <= S_SPLIT_CHK;
            S_SPLIT_CHK: begin
               cur_ff <= '{offset: mrd.offset, size: mrd.size, is_free: 1'b0};
               addr_ff <= cur_addr;
               atally_ff <= sat(atally_ff, 32'd1);
               rsum_ff <= sat(rsum_ff, 32'(s_ff));
               if (cnt_cur < CW'(REGIONS_PER_BLOCK) && (OW+10)'(mrd.size) >= need) begin
                  nb_ff <= '{offset: mrd.offset + OW'(cfg_rhdr_ff) + OW'(s_ff),
                             size: mrd.size - OW'(s_ff) - OW'(cfg_rhdr_ff), is_free: 1'b1};
                  cur_ff <= '{offset: mrd.offset, size: OW'(s_ff), is_free: 1'b0};
                  k_ff <= cnt_cur;
                  count_ff[slot_ff] <= cnt_cur + CW'(1);
                  state_ff <= S_SHR_RD;
               end else begin
                  k_ff <= idx_ff;
                  state_ff <= S_SPLIT_WR;
               end
            end
            // shift tail up one entry
            S_SHR_RD: begin
               if (k_ff == idx_ff + CW'(1)) state_ff <= S_SPLIT_WR;
               else state_ff <= S_SHR_WR;
            end
            S_SHR_WR: begin
               k_ff <= k_ff - CW'(1);
               state_ff <= S_SHR_RD;
            end
            S_SPLIT_WR: begin
               // write the used region, then the free remainder if split
               if (k_ff == idx_ff) begin
                  state_ff <= S_RESP;
               end else begin
                  cur_ff <= nb_ff;
                  idx_ff <= idx_ff + CW'(1);
                  k_ff <= idx_ff + CW'(1);
               end
            end
            S_REL_SLOT: begin
               if (open_ff[slot_ff] && cnt_cur != '0) begin
                  idx_ff <= '0;
                  state_ff <= S_REL_RD;
               end else if (slot_ff == SW'(BLOCK_SLOTS - 1)) begin
                  status_ff <= ST_IGNORED;
                  state_ff <= S_RESP;
               end else begin
                  slot_ff <= slot_ff + SW'(1);
               end
            end
            S_REL_RD: state_ff <= S_REL_CHK;
            S_REL_CHK: begin
               if (!mrd.is_free && cur_addr == req_ff.handle) begin
                  cur_ff <= '{offset: mrd.offset, size: mrd.size, is_free: 1'b1};
                  rtally_ff <= sat(rtally_ff, 32'd1);
                  state_ff <= (idx_ff != '0) ? S_PREV_RD : S_NEXT_RD;
               end else if (idx_ff + CW'(1) < cnt_cur) begin
                  idx_ff <= idx_ff + CW'(1);
                  state_ff <= S_REL_RD;
               end else if (slot_ff == SW'(BLOCK_SLOTS - 1)) begin
                  status_ff <= ST_IGNORED;
                  state_ff <= S_RESP;
               end else begin
                  slot_ff <= slot_ff + SW'(1);
                  state_ff <= S_REL_SLOT;
               end
            end
            S_PREV_RD: state_ff <= S_PREV_CHK;
            S_PREV_CHK: begin
               if (mrd.is_free) begin
                  cur_ff <= '{offset: mrd.offset,
                              size: mrd.size + OW'(cfg_rhdr_ff) + cur_ff.size, is_free: 1'b1};
                  idx_ff <= idx_ff - CW'(1);
                  k_ff <= idx_ff;
                  count_ff[slot_ff] <= cnt_cur - CW'(1);
                  state_ff <= S_SHL_RD;
               end else begin
                  state_ff <= S_NEXT_RD;
               end
            end
            S_NEXT_RD: begin
               if (idx_ff + CW'(1) < cnt_cur) state_ff <= S_NEXT_CHK;
               else state_ff <= S_REL_FIN;
            end
            S_NEXT_CHK: begin
               if (mrd.is_free) begin
                  cur_ff.size <= cur_ff.size + OW'(cfg_rhdr_ff) + mrd.size;
                  k_ff <= idx_ff + CW'(1);
                  count_ff[slot_ff] <= cnt_cur - CW'(1);
                  found_ff <= 1'b1;
                  state_ff <= S_SHL_RD;
               end else begin
                  state_ff <= S_REL_FIN;
               end
            end
            // shift tail down one entry; count already reduced
            S_SHL_RD: begin
               if (k_ff < cnt_cur) state_ff <= S_SHL_WR;
               else if (found_ff) state_ff <= S_REL_FIN;
               else begin
                  found_ff <= 1'b1;
                  state_ff <= S_NEXT_RD;
               end
            end
            S_SHL_WR: begin
               k_ff <= k_ff + CW'(1);
               state_ff <= S_SHL_RD;
            end
            S_REL_FIN: begin
               if (cnt_cur == CW'(1)) begin
                  open_ff[slot_ff] <= 1'b0;
                  count_ff[slot_ff] <= '0;
                  rank_ff[slot_ff] <= '0;
                  for (int b = 0; b < BLOCK_SLOTS; b++)
                     if (open_ff[b] && rank_ff[b] > rank_ff[slot_ff])
                        rank_ff[b] <= rank_ff[b] - SW'(1);
                  if (nopen_ff != '0) nopen_ff <= nopen_ff - NW'(1);
               end
               state_ff <= S_RESP;
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         // merge flag starts clear for each release
         if (state_ff == S_REL_CHK) found_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

>>> sv/schal_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module schal_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> test/tb_size_class_heap_allocator.sv
// Testbench: random and directed allocate/release items checked against a behavioral heap model.
`default_nettype none
module tb_size_class_heap_allocator;
   import schal_pkg::*;

   localparam int unsigned SLOTS = 8;
   localparam int unsigned REGS = 16;
   localparam int unsigned SPAN = 24;

   class heap_scoreboard;
      logic [31:0] cfg_reg [7];
      logic [31:0] r_off [SLOTS*REGS];
      logic [31:0] r_len [SLOTS*REGS];
      bit          r_free [SLOTS*REGS];
      int unsigned r_cnt [SLOTS];
      bit          b_open [SLOTS];
      int unsigned b_cls [SLOTS];
      int unsigned b_rank [SLOTS];
      logic [31:0] n_alloc, n_release, byte_sum;
      int unsigned n_open;
      rsp_type     pending [$];
      int unsigned mismatches;
      logic [ADDR_W-1:0] live [$];

      function void clear();
         cfg_reg[0] = 16384; cfg_reg[1] = 1048576; cfg_reg[2] = 16777216;
         cfg_reg[3] = 256; cfg_reg[4] = 32; cfg_reg[5] = 16; cfg_reg[6] = 0;
         foreach (r_cnt[b]) begin
            r_cnt[b] = 0; b_open[b] = 0; b_cls[b] = 0; b_rank[b] = 0;
         end
         n_alloc = 0; n_release = 0; byte_sum = 0; n_open = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
         case (idx)
            CSR_SMALL, CSR_MEDIUM, CSR_LARGE: cfg_reg[idx] = v & 32'h1FF_FFFF;
            CSR_MINREG: cfg_reg[idx] = v & 32'h1FFF;
            CSR_RHDR, CSR_BHDR: cfg_reg[idx] = v & 32'hFF;
            CSR_FIT: cfg_reg[idx] = v & 32'h1;
            default: ;
         endcase
      endfunction

      function longint unsigned cap(int unsigned c);
         longint unsigned h;
         h = cfg_reg[CSR_RHDR] + cfg_reg[CSR_BHDR];
         return cfg_reg[c] > h ? cfg_reg[c] - h : 0;
      endfunction

      function logic [ADDR_W-1:0] addr_at(int unsigned b, int unsigned i);
         longint unsigned a;
         a = (longint'(b) << SPAN) + cfg_reg[CSR_BHDR] + r_off[b*REGS+i]
             + cfg_reg[CSR_RHDR];
         return a[ADDR_W-1:0];
      endfunction

      function int find_fit(int unsigned b, longint unsigned s);
         int best;
         best = -1;
         for (int unsigned i = 0; i < r_cnt[b]; i++)
            if (r_free[b*REGS+i] && r_len[b*REGS+i] >= s) begin
               if (cfg_reg[CSR_FIT] == 0) return i;
               if (best < 0 || r_len[b*REGS+i] < r_len[b*REGS+best]) best = i;
            end
         return best;
      endfunction

      function void move_entry(int unsigned b, int unsigned dst, int unsigned src);
         r_off[b*REGS+dst] = r_off[b*REGS+src];
         r_len[b*REGS+dst] = r_len[b*REGS+src];
         r_free[b*REGS+dst] = r_free[b*REGS+src];
      endfunction

      function void join_next(int unsigned b, int unsigned j);
         r_len[b*REGS+j] = r_len[b*REGS+j] + cfg_reg[CSR_RHDR] + r_len[b*REGS+j+1];
         for (int unsigned k = j + 1; k + 1 < r_cnt[b]; k++) move_entry(b, k, k + 1);
         r_cnt[b]--;
      endfunction

      function logic [31:0] sat(logic [31:0] a, logic [31:0] v);
         logic [32:0] t;
         t = a + v;
         return t[32] ? 32'hFFFF_FFFF : t[31:0];
      endfunction

      function void allocate(logic [SIZE_W-1:0] req, output logic [1:0] st,
                             output logic [ADDR_W-1:0] ad);
         longint unsigned s, need;
         int fb, fi, c, slot, hit;
         ad = 0; fb = -1; fi = -1;
         if (req == 0) begin st = ST_ZERO; return; end
         s = (longint'(req) + 3) & ~64'd3;
         if (s < cfg_reg[CSR_MINREG]) s = cfg_reg[CSR_MINREG];
         if (s <= cap(2))
            for (c = 0; c < 3 && fb < 0; c++)
               for (int unsigned rk = 0; rk < SLOTS && fb < 0; rk++)
                  for (int unsigned b = 0; b < SLOTS; b++)
                     if (b_open[b] && b_cls[b] == c && b_rank[b] == rk) begin
                        hit = find_fit(b, s);
                        if (hit >= 0) begin fb = b; fi = hit; end
                        break;
                     end
         if (fb < 0) begin
            st = ST_OOM;
            if (n_open >= SLOTS) return;
            for (c = 0; c < 3; c++) if (s <= cap(c)) break;
            if (c >= 3) return;
            for (slot = 0; slot < SLOTS; slot++) if (!b_open[slot]) break;
            if (slot >= SLOTS) return;
            foreach (b_open[b]) if (b_open[b]) b_rank[b]++;
            b_open[slot] = 1; b_cls[slot] = c; b_rank[slot] = 0; r_cnt[slot] = 1;
            r_off[slot*REGS] = 0; r_len[slot*REGS] = 32'(cap(c)); r_free[slot*REGS] = 1;
            n_open++;
            fb = slot; fi = 0;
         end
         need = s + cfg_reg[CSR_RHDR] + cfg_reg[CSR_MINREG];
         if (r_cnt[fb] < REGS && r_len[fb*REGS+fi] >= need) begin
            for (int unsigned k = r_cnt[fb]; k > fi + 1; k--) move_entry(fb, k, k - 1);
            r_off[fb*REGS+fi+1] = 32'(r_off[fb*REGS+fi] + cfg_reg[CSR_RHDR] + s);
            r_len[fb*REGS+fi+1] = 32'(r_len[fb*REGS+fi] - s - cfg_reg[CSR_RHDR]);
            r_free[fb*REGS+fi+1] = 1;
            r_len[fb*REGS+fi] = 32'(s);
            r_cnt[fb]++;
         end
         r_free[fb*REGS+fi] = 0;
         n_alloc = sat(n_alloc, 1);
         byte_sum = sat(byte_sum, s[31:0]);
         ad = addr_at(fb, fi);
         st = ST_DONE;
      endfunction

      function logic [1:0] release_handle(logic [ADDR_W-1:0] h);
         int unsigned b, i, r;
         if (h == 0) return ST_IGNORED;
         for (b = 0; b < SLOTS; b++) begin
            if (!b_open[b]) continue;
            for (i = 0; i < r_cnt[b]; i++)
               if (!r_free[b*REGS+i] && addr_at(b, i) == h) break;
            if (i < r_cnt[b]) break;
         end
         if (b >= SLOTS) return ST_IGNORED;
         r_free[b*REGS+i] = 1;
         if (i > 0 && r_free[b*REGS+i-1]) begin join_next(b, i - 1); i--; end
         if (i + 1 < r_cnt[b] && r_free[b*REGS+i+1]) join_next(b, i);
         n_release = sat(n_release, 1);
         if (r_cnt[b] == 1) begin
            r = b_rank[b];
            b_open[b] = 0; r_cnt[b] = 0;
            foreach (b_open[k]) if (b_open[k] && b_rank[k] > r) b_rank[k]--;
            b_rank[b] = 0;
            if (n_open > 0) n_open--;
         end
         return ST_DONE;
      endfunction

      function void note_item(req_type it);
         rsp_type e;
         logic [1:0] st;
         logic [ADDR_W-1:0] ad;
         ad = 0;
         if (it.cmd == CMD_ALLOC) allocate(it.request_bytes, st, ad);
         else st = release_handle(it.handle);
         if (st == ST_DONE && it.cmd == CMD_ALLOC) live.push_back(ad);
         e.status = st; e.address = ad; e.alloc_count = n_alloc;
         e.release_count = n_release; e.requested_total = byte_sum;
         e.blocks_open = n_open[3:0];
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", e, got);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0, csr_valid = 0;
   logic busy, rsp_valid, csr_ready;
   req_type req_item = '0;
   rsp_type rsp_item;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   heap_scoreboard heap = new();
   bit calm = 0;

   always #4 clock = ~clock;

   size_class_heap_allocator DUT (
      .clock, .reset, .start, .busy, .req_item, .rsp_valid, .rsp_item,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always @(posedge clock)
      if (!reset && rsp_valid) heap.check_result(rsp_item);

   task automatic gap();
      if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 14)) @(posedge clock);
   endtask

   task automatic send_item(req_type it);
      gap();
      start <= 1; req_item <= it;
      do @(posedge clock); while (busy);
      heap.note_item(it);
      start <= 0;
      @(posedge clock);
   endtask

   task automatic settle();
      while (heap.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      csr_valid <= 1; csr_index <= idx; csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      heap.write_reg(idx, v);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic req_type make_alloc(logic [SIZE_W-1:0] n);
      req_type it;
      it = '0; it.cmd = CMD_ALLOC; it.request_bytes = n;
      it.handle = ADDR_W'($urandom());
      return it;
   endfunction

   function automatic req_type make_release(logic [ADDR_W-1:0] h);
      req_type it;
      it = '0; it.cmd = CMD_RELEASE; it.handle = h;
      it.request_bytes = SIZE_W'($urandom());
      return it;
   endfunction

   // release everything still live so blocks close before a reconfiguration
   task automatic drain_heap();
      while (heap.live.size() != 0) send_item(make_release(heap.live.pop_front()));
   endtask

   task automatic random_phase(int unsigned n);
      int unsigned k, pick;
      logic [SIZE_W-1:0] sz;
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50 || heap.live.size() == 0) begin
            case ($urandom_range(0, 9))
               0: sz = SIZE_W'($urandom());
               1: sz = SIZE_W'($urandom_range(0, 3));
               2: sz = SIZE_W'($urandom_range(1, 25'h1FF_FFFF));
               default: sz = SIZE_W'($urandom_range(1, 2048));
            endcase
            send_item(make_alloc(sz));
         end else if (pick < 85) begin
            pick = $urandom_range(0, heap.live.size() - 1);
            send_item(make_release(heap.live[pick]));
            heap.live.delete(pick);
         end else if (pick < 92) begin
            send_item(make_release(heap.live[$urandom_range(0, heap.live.size() - 1)]));
         end else begin
            send_item(make_release(ADDR_W'($urandom())));
         end
      end
   endtask

   task automatic load_config(logic [31:0] s, logic [31:0] m, logic [31:0] l,
                              logic [31:0] mr, logic [31:0] rh, logic [31:0] bh,
                              logic [31:0] fit);
      write_csr(CSR_SMALL, s); write_csr(CSR_MEDIUM, m); write_csr(CSR_LARGE, l);
      write_csr(CSR_MINREG, mr); write_csr(CSR_RHDR, rh); write_csr(CSR_BHDR, bh);
      write_csr(CSR_FIT, fit);
   endtask

   initial begin
      heap.clear();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: zero, extremes, null and bogus releases, reuse
      send_item(make_alloc(SIZE_W'(0)));
      send_item(make_alloc(SIZE_W'(1)));
      send_item(make_alloc(25'h1FF_FFFF));
      send_item(make_alloc(25'd16777216));
      send_item(make_alloc(25'd16777168));
      send_item(make_release('0));
      send_item(make_release({ADDR_W{1'b1}}));
      send_item(make_release(heap.live[0]));
      send_item(make_release(heap.live[0]));
      heap.live.delete(0);
      for (int i = 0; i < 18; i++) send_item(make_alloc(SIZE_W'(700)));
      settle();
      random_phase(300);
      drain_heap();
      settle();
      load_config(64, 2048, 65536, 4, 0, 0, 1);
      random_phase(400);
      settle();
      // configuration change with blocks open: tables kept
      load_config(25'h1FF_FFFF, 25'h1FF_FFFF, 16777216, 4096, 255, 255, 0);
      random_phase(300);
      drain_heap();
      settle();
      load_config(300, 1200, 8000, 8, 16, 8, 1);
      random_phase(500);
      settle();
      load_config(40, 60, 64, 12, 255, 0, 0);
      random_phase(150);
      settle();
      load_config(16384, 1048576, 16777216, 256, 32, 16, 0);
      calm = 1;
      random_phase(350);
      settle();
      if (heap.mismatches == 0 && heap.pending.size() == 0)
         $display("[size_class_heap_allocator] OK");
      else
         $display("[size_class_heap_allocator] ERROR");
      $finish;
   end

   initial begin
      #40000000;
      $display("[size_class_heap_allocator] ERROR");
      $finish;
   end
endmodule
`default_nettype wire
